// ===== design/tfdm_pkg.sv =====
// Shared types and constants for the three-frame difference mask.
// Holds the configuration struct, register indexes, reset values and frame phase codes.
// No dependencies.
`default_nettype none

package tfdm_pkg;

    localparam int DEF_MAX_FRAME_PIXELS = 65536;

    localparam int PIX_W  = 8;
    localparam int POS_W  = 16;
    localparam int PPF_W  = 17;
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD_FIRST  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD_SECOND = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_COMBINE_WITH_XOR = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SEPARATE_TRIPLES = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PIXELS_PER_FRAME = 3'd4;

    localparam logic [PIX_W-1:0] RST_THRESHOLD_FIRST  = 8'd20;
    localparam logic [PIX_W-1:0] RST_THRESHOLD_SECOND = 8'd20;
    localparam logic             RST_COMBINE_WITH_XOR = 1'b1;
    localparam logic             RST_SEPARATE_TRIPLES = 1'b0;
    localparam logic [PPF_W-1:0] RST_PIXELS_PER_FRAME = 17'd57600;

    typedef struct packed {
        logic [PIX_W-1:0] threshold_first;
        logic [PIX_W-1:0] threshold_second;
        logic             combine_with_xor;
        logic             separate_triples;
        logic [PPF_W-1:0] pixels_per_frame;
    } t_cfg;

    typedef enum logic [2:0] {
        PH_OLDER   = 3'b001,
        PH_MIDDLE  = 3'b010,
        PH_COMPARE = 3'b100
    } t_phase;

    typedef struct packed {
        t_phase phase;
        logic   last;
    } t_ctl;

    function automatic logic [PIX_W-1:0] sat_sub(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
        logic [PIX_W:0] d;
        d = {1'b0, a} - {1'b0, b};
        return d[PIX_W] ? '0 : d[PIX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/tfdm_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// The read data only changes on a cycle with the read enable high. No dependencies.
`default_nettype none

module tfdm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/tfdm_cfg.sv =====
// APB-style configuration registers for the three-frame difference mask.
// Depends on tfdm_pkg for the register map, reset values and the t_cfg struct.
`default_nettype none

module tfdm_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [tfdm_pkg::APB_AW-1:0]    paddr,
    input  wire logic [tfdm_pkg::APB_DW-1:0]    pwdata,
    output logic      [tfdm_pkg::APB_DW-1:0]    prdata,
    output logic                                pready,
    output tfdm_pkg::t_cfg                      o_cfg
);

    import tfdm_pkg::*;

    t_cfg                   r_cfg;
    t_cfg                   n_cfg;
    logic [REG_IDX_W-1:0]   idx;
    logic                   wr;

    assign idx    = paddr[APB_AW-1:2];
    assign wr     = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr) begin
            unique case (idx)
                REG_THRESHOLD_FIRST:  n_cfg.threshold_first  = pwdata[PIX_W-1:0];
                REG_THRESHOLD_SECOND: n_cfg.threshold_second = pwdata[PIX_W-1:0];
                REG_COMBINE_WITH_XOR: n_cfg.combine_with_xor = pwdata[0];
                REG_SEPARATE_TRIPLES: n_cfg.separate_triples = pwdata[0];
                REG_PIXELS_PER_FRAME: n_cfg.pixels_per_frame = pwdata[PPF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_THRESHOLD_FIRST:  prdata = APB_DW'(r_cfg.threshold_first);
            REG_THRESHOLD_SECOND: prdata = APB_DW'(r_cfg.threshold_second);
            REG_COMBINE_WITH_XOR: prdata = APB_DW'(r_cfg.combine_with_xor);
            REG_SEPARATE_TRIPLES: prdata = APB_DW'(r_cfg.separate_triples);
            REG_PIXELS_PER_FRAME: prdata = APB_DW'(r_cfg.pixels_per_frame);
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold_first  <= RST_THRESHOLD_FIRST;
            r_cfg.threshold_second <= RST_THRESHOLD_SECOND;
            r_cfg.combine_with_xor <= RST_COMBINE_WITH_XOR;
            r_cfg.separate_triples <= RST_SEPARATE_TRIPLES;
            r_cfg.pixels_per_frame <= RST_PIXELS_PER_FRAME;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

// ===== design/tfdm_frame_ctl.sv =====
// Pixel counter and frame phase sequencer.
// Gives the raster position, the end-of-frame flag and the phase of each accepted item.
// Depends on tfdm_pkg.
`default_nettype none

module tfdm_frame_ctl #(
    parameter int MAX_FRAME_PIXELS = tfdm_pkg::DEF_MAX_FRAME_PIXELS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire tfdm_pkg::t_cfg                      i_cfg,
    input  wire logic                                i_accept,
    output logic      [$clog2(MAX_FRAME_PIXELS)-1:0] o_pos,
    output tfdm_pkg::t_ctl                           o_ctl
);

    import tfdm_pkg::*;

    localparam int AW = $clog2(MAX_FRAME_PIXELS);
    localparam int CW = (AW + 1 > PPF_W) ? AW + 1 : PPF_W;
    localparam logic [CW-1:0] MAX_LEN = CW'(MAX_FRAME_PIXELS);

    logic [AW-1:0] r_count;
    logic [AW-1:0] n_count;
    t_phase        r_phase;
    t_phase        n_phase;
    logic [CW-1:0] len_req;
    logic [CW-1:0] len;
    logic          last;

    always_comb begin
        len_req = (i_cfg.pixels_per_frame == '0) ? CW'(1) : CW'(i_cfg.pixels_per_frame);
        len     = (len_req > MAX_LEN) ? MAX_LEN : len_req;
        last    = (CW'(r_count) + CW'(1)) >= len;
    end

    always_comb begin
        n_count = r_count;
        n_phase = r_phase;
        if (i_accept) begin
            if (last) begin
                n_count = '0;
                unique case (r_phase)
                    PH_OLDER:   n_phase = PH_MIDDLE;
                    PH_MIDDLE:  n_phase = PH_COMPARE;
                    PH_COMPARE: n_phase = i_cfg.separate_triples ? PH_OLDER : PH_COMPARE;
                    default:    n_phase = PH_OLDER;
                endcase
            end else begin
                n_count = r_count + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_phase <= PH_OLDER;
        end else begin
            r_count <= n_count;
            r_phase <= n_phase;
        end
    end

    assign o_pos       = r_count;
    assign o_ctl.phase = r_phase;
    assign o_ctl.last  = last;

endmodule

`default_nettype wire

// ===== design/tfdm_pipe.sv =====
// Three-stage compare pipeline with the older and middle frame stores.
// Stage one reads and writes back the stores, stage two holds the clamped differences,
// stage three is the output register. Depends on tfdm_pkg and tfdm_ram.
`default_nettype none

module tfdm_pipe #(
    parameter int MAX_FRAME_PIXELS = tfdm_pkg::DEF_MAX_FRAME_PIXELS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire tfdm_pkg::t_cfg                      i_cfg,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [tfdm_pkg::PIX_W-1:0]          i_gray_pixel,
    input  wire logic [$clog2(MAX_FRAME_PIXELS)-1:0] i_pos,
    input  wire tfdm_pkg::t_ctl                      i_ctl,
    output logic                                     o_accept,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic                                     o_motion_bit,
    output logic      [tfdm_pkg::POS_W-1:0]          o_pixel_position,
    output logic                                     o_frame_end
);

    import tfdm_pkg::*;

    localparam int AW = $clog2(MAX_FRAME_PIXELS);

    logic ready1;
    logic ready2;
    logic ready3;
    logic accept;

    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_pix;
    logic [AW-1:0]    r_s1_pos;
    t_ctl             r_s1_ctl;
    logic             r_s1_fwd_old;
    logic             r_s1_fwd_mid;
    logic [PIX_W-1:0] r_s1_fwd_old_d;
    logic [PIX_W-1:0] r_s1_fwd_mid_d;

    logic [PIX_W-1:0] old_rd;
    logic [PIX_W-1:0] mid_rd;
    logic [PIX_W-1:0] old_v;
    logic [PIX_W-1:0] mid_v;
    logic             s1_go;
    logic             we_old;
    logic             we_mid;
    logic [PIX_W-1:0] wd_old;
    logic             same_addr;

    logic             r_s2_valid;
    logic [PIX_W-1:0] r_s2_d1;
    logic [PIX_W-1:0] r_s2_d2;
    logic [POS_W-1:0] r_s2_pos;
    logic             r_s2_last;

    logic             r_out_valid;
    logic             r_out_motion;
    logic [POS_W-1:0] r_out_pos;
    logic             r_out_last;
    logic             b1;
    logic             b2;

    assign ready3     = !r_out_valid || !i_out_stall;
    assign ready2     = !r_s2_valid || ready3;
    assign ready1     = !r_s1_valid || ready2;
    assign accept     = i_in_valid && ready1;
    assign o_in_stall = !ready1;
    assign o_accept   = accept;

    assign old_v     = r_s1_fwd_old ? r_s1_fwd_old_d : old_rd;
    assign mid_v     = r_s1_fwd_mid ? r_s1_fwd_mid_d : mid_rd;
    assign s1_go     = r_s1_valid && ready2;
    assign we_old    = s1_go && (r_s1_ctl.phase == PH_OLDER || r_s1_ctl.phase == PH_COMPARE);
    assign we_mid    = s1_go && (r_s1_ctl.phase == PH_MIDDLE || r_s1_ctl.phase == PH_COMPARE);
    assign wd_old    = (r_s1_ctl.phase == PH_COMPARE) ? mid_v : r_s1_pix;
    assign same_addr = r_s1_pos == i_pos;

    tfdm_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_FRAME_PIXELS)
    ) u_older_ram (
        .i_clk     (i_clk),
        .i_wr_en   (we_old),
        .i_wr_addr (r_s1_pos),
        .i_wr_data (wd_old),
        .i_rd_en   (accept),
        .i_rd_addr (i_pos),
        .o_rd_data (old_rd)
    );

    tfdm_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_FRAME_PIXELS)
    ) u_middle_ram (
        .i_clk     (i_clk),
        .i_wr_en   (we_mid),
        .i_wr_addr (r_s1_pos),
        .i_wr_data (r_s1_pix),
        .i_rd_en   (accept),
        .i_rd_addr (i_pos),
        .o_rd_data (mid_rd)
    );

    // A write leaving stage one lands at the same edge as the next read, so it is forwarded.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix       <= i_gray_pixel;
            r_s1_pos       <= i_pos;
            r_s1_ctl       <= i_ctl;
            r_s1_fwd_old   <= we_old && same_addr;
            r_s1_fwd_mid   <= we_mid && same_addr;
            r_s1_fwd_old_d <= wd_old;
            r_s1_fwd_mid_d <= r_s1_pix;
        end
        if (s1_go) begin
            r_s2_d1   <= sat_sub(mid_v, old_v);
            r_s2_d2   <= sat_sub(r_s1_pix, mid_v);
            r_s2_pos  <= POS_W'(r_s1_pos);
            r_s2_last <= r_s1_ctl.last;
        end
        if (ready3 && r_s2_valid) begin
            r_out_motion <= i_cfg.combine_with_xor ? (b1 ^ b2) : (b1 | b2);
            r_out_pos    <= r_s2_pos;
            r_out_last   <= r_s2_last;
        end
    end

    assign b1 = r_s2_d1 >= i_cfg.threshold_first;
    assign b2 = r_s2_d2 >= i_cfg.threshold_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (ready1) begin
                r_s1_valid <= i_in_valid;
            end
            if (ready2) begin
                r_s2_valid <= r_s1_valid && (r_s1_ctl.phase == PH_COMPARE);
            end
            if (ready3) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_motion_bit     = r_out_motion;
    assign o_pixel_position = r_out_pos;
    assign o_frame_end      = r_out_last;

endmodule

`default_nettype wire

// ===== design/three_frame_difference_mask.sv =====
// Top level of the three-frame difference motion mask.
// Depends on tfdm_pkg, tfdm_cfg, tfdm_frame_ctl, tfdm_pipe and tfdm_ram.
//
//   Channel   Handshake                    Payload
//   input     i_in_valid / o_in_stall      i_gray_pixel
//   output    o_out_valid / i_out_stall    o_motion_bit, o_pixel_position, o_frame_end
//   config    psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// One pixel is taken every clock while the pipeline is not stalled; results leave registered.
// The rate is set by the frame stores, each one RAM with one write and one read port.
// Pixels of the first two frames of a window are stored and give no item.
// Reset clears the registers, the pixel counter and the frame phase; the stores are not cleared.
// A stall on the output holds the pipeline and, with every stage full, reaches the input stall at once.
`default_nettype none

module three_frame_difference_mask #(
    parameter int MAX_FRAME_PIXELS = tfdm_pkg::DEF_MAX_FRAME_PIXELS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tfdm_pkg::APB_AW-1:0]   paddr,
    input  wire logic [tfdm_pkg::APB_DW-1:0]   pwdata,
    output logic      [tfdm_pkg::APB_DW-1:0]   prdata,
    output logic                               pready,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [tfdm_pkg::PIX_W-1:0]    i_gray_pixel,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_motion_bit,
    output logic      [tfdm_pkg::POS_W-1:0]    o_pixel_position,
    output logic                               o_frame_end
);

    import tfdm_pkg::*;

    localparam int AW = $clog2(MAX_FRAME_PIXELS);

    t_cfg          cfg;
    t_ctl          ctl;
    logic [AW-1:0] pos;
    logic          accept;

    tfdm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tfdm_frame_ctl #(
        .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS)
    ) u_frame_ctl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_accept (accept),
        .o_pos    (pos),
        .o_ctl    (ctl)
    );

    tfdm_pipe #(
        .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS)
    ) u_pipe (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_gray_pixel     (i_gray_pixel),
        .i_pos            (pos),
        .i_ctl            (ctl),
        .o_accept         (accept),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_motion_bit     (o_motion_bit),
        .o_pixel_position (o_pixel_position),
        .o_frame_end      (o_frame_end)
    );

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Testbench for three_frame_difference_mask: streams gray pixels through the block and checks
// every motion result against a frame-store predictor kept in this file.
// Depends on tfdm_pkg and the three_frame_difference_mask RTL.

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tfdm_pkg::*;

    localparam int FRAME_MAX     = DEF_MAX_FRAME_PIXELS;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_AFTER    = 150;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_PIXELS = 1800;
    localparam int TAIL_PIXELS   = 100;

    localparam logic [REG_IDX_W-1:0] REG_UNUSED_LOW = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_UNUSED_TOP = 3'd7;

    localparam logic COMBINE_OR    = 1'b0;
    localparam logic COMBINE_XOR   = 1'b1;
    localparam logic MODE_SLIDING  = 1'b0;
    localparam logic MODE_TRIPLES  = 1'b1;

    localparam logic [PIX_W-1:0] OPENING [12] = '{
        8'h00, 8'hFF, 8'h00,
        8'hFF, 8'hFF, 8'h00,
        8'h00, 8'h00, 8'hFF,
        8'hFF, 8'hFF, 8'hFF
    };

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [3:0]       gap;
    } t_feed;

    typedef struct packed {
        logic             motion;
        logic [POS_W-1:0] pos;
        logic             fend;
    } t_mask;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    logic             in_valid = 1'b0;
    logic             in_stall;
    logic [PIX_W-1:0] gray = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic             motion_bit;
    logic [POS_W-1:0] pixel_position;
    logic             frame_end;

    logic [PIX_W-1:0] older_px  [FRAME_MAX];
    logic [PIX_W-1:0] middle_px [FRAME_MAX];
    int unsigned      older_fill = 0;
    int unsigned      middle_fill = 0;
    int unsigned      pix_count = 0;
    t_phase           phase = PH_OLDER;

    logic [PIX_W-1:0] thr_first = RST_THRESHOLD_FIRST;
    logic [PIX_W-1:0] thr_second = RST_THRESHOLD_SECOND;
    logic             xor_mode = RST_COMBINE_WITH_XOR;
    logic             triples_mode = RST_SEPARATE_TRIPLES;
    logic [PPF_W-1:0] frame_pixels = RST_PIXELS_PER_FRAME;

    t_mask mask_q[$];
    t_feed feed_q[$];
    t_feed pending;
    t_mask head;
    bit    staged = 1'b0;
    bit    hold_done = 1'b0;
    int    stall_left = 0;
    int    n_fed = 0;
    int    n_taken = 0;
    int    n_results = 0;
    int    n_errors = 0;
    bit    tx_idle_on = 1'b1;
    bit    rx_idle_on = 1'b1;

    three_frame_difference_mask u_top (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_gray_pixel     (gray),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_motion_bit     (motion_bit),
        .o_pixel_position (pixel_position),
        .o_frame_end      (frame_end)
    );

    initial forever #10 clk = ~clk;

    function automatic void predict_pixel(input logic [PIX_W-1:0] pix);
        int unsigned      len;
        int unsigned      pos;
        logic             last;
        logic [PIX_W-1:0] ov;
        logic [PIX_W-1:0] mv;
        logic [PIX_W-1:0] rise1;
        logic [PIX_W-1:0] rise2;
        logic             hit1;
        logic             hit2;
        t_mask            r;
        len = 32'(frame_pixels);
        if (len == 0) len = 1;
        if (len > FRAME_MAX) len = FRAME_MAX;
        pos = (pix_count >= FRAME_MAX) ? FRAME_MAX - 1 : pix_count;
        last = (pix_count + 1 >= len);
        case (phase)
            PH_OLDER: begin
                older_px[pos] = pix;
                if (pos >= older_fill) older_fill = pos + 1;
            end
            PH_MIDDLE: begin
                middle_px[pos] = pix;
                if (pos >= middle_fill) middle_fill = pos + 1;
            end
            default: begin
                ov = older_px[pos];
                mv = middle_px[pos];
                rise1 = (mv > ov) ? mv - ov : '0;
                rise2 = (pix > mv) ? pix - mv : '0;
                hit1 = (rise1 >= thr_first);
                hit2 = (rise2 >= thr_second);
                r.motion = xor_mode ? (hit1 ^ hit2) : (hit1 | hit2);
                r.pos = pos[POS_W-1:0];
                r.fend = last;
                mask_q.push_back(r);
                older_px[pos] = mv;
                middle_px[pos] = pix;
            end
        endcase
        if (last) begin
            pix_count = 0;
            case (phase)
                PH_OLDER:  phase = PH_MIDDLE;
                PH_MIDDLE: phase = PH_COMPARE;
                default:   if (triples_mode) phase = PH_OLDER;
            endcase
        end else begin
            pix_count++;
        end
    endfunction

    // A compared frame may only cover store entries that some earlier frame has written.
    function automatic int unsigned longest_safe_frame();
        case (phase)
            PH_OLDER:  return FRAME_MAX;
            PH_MIDDLE: return older_fill;
            default:   return (older_fill < middle_fill) ? older_fill : middle_fill;
        endcase
    endfunction

    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] val);
        logic [APB_DW-1:0] keep;
        case (idx)
            REG_THRESHOLD_FIRST, REG_THRESHOLD_SECOND: keep = 32'h0000_00FF;
            REG_COMBINE_WITH_XOR, REG_SEPARATE_TRIPLES: keep = 32'h0000_0001;
            REG_PIXELS_PER_FRAME: keep = 32'h0001_FFFF;
            default: keep = '0;
        endcase
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= (val & keep) | ($urandom() & ~keep);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_THRESHOLD_FIRST:  thr_first = val[PIX_W-1:0];
            REG_THRESHOLD_SECOND: thr_second = val[PIX_W-1:0];
            REG_COMBINE_WITH_XOR: xor_mode = val[0];
            REG_SEPARATE_TRIPLES: triples_mode = val[0];
            REG_PIXELS_PER_FRAME: frame_pixels = val[PPF_W-1:0];
            default: ;
        endcase
    endtask

    task automatic check_registers();
        logic [APB_DW-1:0] want;
        int                idx;
        for (idx = 0; idx <= REG_PIXELS_PER_FRAME; idx++) begin
            case (idx)
                REG_THRESHOLD_FIRST:  want = APB_DW'(thr_first);
                REG_THRESHOLD_SECOND: want = APB_DW'(thr_second);
                REG_COMBINE_WITH_XOR: want = APB_DW'(xor_mode);
                REG_SEPARATE_TRIPLES: want = APB_DW'(triples_mode);
                default:              want = APB_DW'(frame_pixels);
            endcase
            @(posedge clk);
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b0;
            paddr <= {idx[REG_IDX_W-1:0], 2'b00};
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            if (prdata !== want) begin
                $error("register %0d: expected %0h, got %0h", idx, want, prdata);
                n_errors++;
            end
            psel <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    task automatic feed_pixel(input logic [PIX_W-1:0] pix);
        t_feed f;
        f.pixel = pix;
        f.gap = (tx_idle_on && $urandom_range(0, 3) == 0) ? 4'($urandom_range(1, 5)) : 4'd0;
        feed_q.push_back(f);
        n_fed++;
    endtask

    task automatic drain();
        while (n_taken != n_fed || mask_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic retune();
        int unsigned want_len;
        reg_write(REG_THRESHOLD_FIRST,
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 60));
        reg_write(REG_THRESHOLD_SECOND,
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 60));
        reg_write(REG_COMBINE_WITH_XOR, $urandom_range(0, 1) ? COMBINE_XOR : COMBINE_OR);
        reg_write(REG_SEPARATE_TRIPLES, $urandom_range(0, 1) ? MODE_TRIPLES : MODE_SLIDING);
        case ($urandom_range(0, 9))
            0:       want_len = 0;
            1:       want_len = $urandom_range(13, 80);
            default: want_len = $urandom_range(1, 12);
        endcase
        if (want_len > longest_safe_frame()) want_len = longest_safe_frame();
        reg_write(REG_PIXELS_PER_FRAME, want_len);
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            gray <= '0;
        end else begin
            if (in_valid && !in_stall) begin
                predict_pixel(gray);
                n_taken++;
            end
            if (!in_valid || !in_stall) begin
                if (!staged && feed_q.size() != 0) begin
                    pending = feed_q.pop_front();
                    staged = 1'b1;
                end
                if (staged && pending.gap == 0) begin
                    in_valid <= 1'b1;
                    gray <= pending.pixel;
                    staged = 1'b0;
                end else begin
                    in_valid <= 1'b0;
                    if (staged) pending.gap = pending.gap - 4'd1;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                n_results++;
                if (mask_q.size() == 0) begin
                    $error("result at position %0d with nothing expected", pixel_position);
                    n_errors++;
                end else begin
                    head = mask_q.pop_front();
                    if (motion_bit !== head.motion) begin
                        $error("motion_bit: expected %0d, got %0d", head.motion, motion_bit);
                        n_errors++;
                    end
                    if (pixel_position !== head.pos) begin
                        $error("pixel_position: expected %0d, got %0d", head.pos, pixel_position);
                        n_errors++;
                    end
                    if (frame_end !== head.fend) begin
                        $error("frame_end: expected %0d, got %0d", head.fend, frame_end);
                        n_errors++;
                    end
                end
            end
            // One long hold-off lets the pipeline fill and push back on the input.
            if (!hold_done && n_results >= HOLD_AFTER) begin
                hold_done = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left != 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                stall_left = $urandom_range(0, 4);
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    initial begin
        int i;
        int pixels_left;
        int seg;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_registers();

        reg_write(REG_THRESHOLD_FIRST, 255);
        reg_write(REG_THRESHOLD_SECOND, 255);
        reg_write(REG_COMBINE_WITH_XOR, COMBINE_OR);
        reg_write(REG_SEPARATE_TRIPLES, MODE_SLIDING);
        reg_write(REG_PIXELS_PER_FRAME, 3);
        for (i = 0; i < 12; i++) feed_pixel(OPENING[i]);
        drain();

        // A frame length of zero behaves as a single pixel.
        reg_write(REG_THRESHOLD_FIRST, 0);
        reg_write(REG_THRESHOLD_SECOND, 0);
        reg_write(REG_COMBINE_WITH_XOR, COMBINE_XOR);
        reg_write(REG_PIXELS_PER_FRAME, 0);
        feed_pixel(8'h00);
        feed_pixel(8'hFF);
        drain();

        // Shrink the frame below the current position; the next pixel closes the frame.
        reg_write(REG_PIXELS_PER_FRAME, 3);
        feed_pixel(8'hA5);
        feed_pixel(8'h5A);
        drain();
        reg_write(REG_PIXELS_PER_FRAME, 1);
        feed_pixel(8'h80);
        drain();

        reg_write(REG_THRESHOLD_FIRST, 128);
        reg_write(REG_THRESHOLD_SECOND, 1);
        reg_write(REG_SEPARATE_TRIPLES, MODE_TRIPLES);
        reg_write(REG_PIXELS_PER_FRAME, 2);
        reg_write(REG_UNUSED_LOW, $urandom());
        reg_write(REG_UNUSED_TOP, $urandom());
        check_registers();
        feed_pixel(8'h00);
        feed_pixel(8'h80);
        feed_pixel(8'h7F);
        feed_pixel(8'hFF);
        feed_pixel(8'h01);
        feed_pixel(8'hFE);

        pixels_left = RANDOM_PIXELS;
        while (pixels_left > 0) begin
            drain();
            retune();
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            seg = $urandom_range(60, 240);
            repeat (seg) begin
                if ($urandom_range(0, 7) == 0)
                    feed_pixel($urandom_range(0, 1) ? 8'hFF : 8'h00);
                else
                    feed_pixel(PIX_W'($urandom_range(0, 255)));
            end
            pixels_left -= seg;
        end

        // The closing stretch runs with no idle cycles on either side.
        drain();
        check_registers();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (TAIL_PIXELS) feed_pixel(PIX_W'($urandom_range(0, 255)));
        drain();

        if (n_errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("tb: done, errors");
        $finish;
    end

endmodule
